FILE: hw/rtl/multi_class_min_extract_queue_defines.svh
// ============================================================================
// Assertion macros for the multi-class min-extract queue
// Shared concurrent assertion forms used by the RTL modules.
// ============================================================================
`ifndef MULTI_CLASS_MIN_EXTRACT_QUEUE_DEFINES_SVH
`define MULTI_CLASS_MIN_EXTRACT_QUEUE_DEFINES_SVH

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define MCMQ_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// cond must never hold at a clock edge outside reset.
`define MCMQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error(msg);

`endif

FILE: hw/rtl/mcmq_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// Multi-class min-extract queue package
// Sizes, result codes, sequencer states and the types shared by the cells.
// ============================================================================
package mcmq_pkg;

    localparam int ENTRIES    = 256;
    localparam int KEY_W      = 30;
    localparam int TAG_W      = 2;
    localparam int MASK_W     = 3;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 32;

    localparam logic [STATUS_W-1:0] STAT_STORED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FOUND  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } seq_state_t;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [MASK_W-1:0] mask;
    } cell_data_t;

    localparam cell_data_t EMPTY_CELL = '{valid: 1'b0, key: '0, mask: '0};

    // Broadcast from the sequencer to every cell.
    typedef struct packed {
        logic              cmp_en;
        logic              commit;
        logic              func;
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mask;
        logic [MASK_W-1:0] want;
        logic              hit;
        logic              full;
        logic              found;
    } cell_ctrl_t;

    // Tag 0 names no class; tag k sets bit k-1.
    function automatic logic [MASK_W-1:0] class_bit(input logic [TAG_W-1:0] tag);
        logic [MASK_W-1:0] m;
        m = '0;
        unique case (tag)
            2'd1:    m = 3'b001;
            2'd2:    m = 3'b010;
            2'd3:    m = 3'b100;
            default: m = '0;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/mcmq_cell.sv
`timescale 1ns / 1ps
// ============================================================================
// Queue cell
// Holds one entry of the sorted chain, compares it against the broadcast
// key and takes an entry from either neighbor when the chain shifts.
// ============================================================================
`include "multi_class_min_extract_queue_defines.svh"

module mcmq_cell
    import mcmq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  cell_data_t prev_data,
    input  logic       prev_gt,
    input  cell_data_t next_data,
    input  logic       shift_down,
    output cell_data_t data,
    output logic       gt,
    output logic       eq,
    output logic       match
);

    logic              valid_reg, valid_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [MASK_W-1:0] mask_reg, mask_next;
    logic              gt_reg, gt_next;
    logic              eq_reg, eq_next;

    assign data  = '{valid: valid_reg, key: key_reg, mask: mask_reg};
    assign gt    = gt_reg;
    assign eq    = eq_reg;
    assign match = valid_reg && ((mask_reg & ctrl.want) != '0);

    // An empty cell counts as greater, so the first greater cell is the
    // insertion point of a new key.
    always_comb begin
        gt_next = gt_reg;
        eq_next = eq_reg;
        if (ctrl.cmp_en) begin
            gt_next = !valid_reg || (key_reg > ctrl.key);
            eq_next = valid_reg && (key_reg == ctrl.key);
        end
    end

    always_comb begin
        valid_next = valid_reg;
        key_next   = key_reg;
        mask_next  = mask_reg;
        if (ctrl.commit) begin
            if (ctrl.func == FUNC_INSERT) begin
                if (ctrl.hit) begin
                    if (eq_reg) begin
                        mask_next = ctrl.mask;
                    end
                end else if (!ctrl.full && gt_reg) begin
                    if (prev_gt) begin
                        valid_next = prev_data.valid;
                        key_next   = prev_data.key;
                        mask_next  = prev_data.mask;
                    end else begin
                        valid_next = 1'b1;
                        key_next   = ctrl.key;
                        mask_next  = ctrl.mask;
                    end
                end
            end else if (ctrl.found && shift_down) begin
                valid_next = next_data.valid;
                key_next   = next_data.key;
                mask_next  = next_data.mask;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg  <= key_next;
        mask_reg <= mask_next;
        gt_reg   <= gt_next;
        eq_reg   <= eq_next;
    end

    `MCMQ_ASSERT_IMPLY(a_sorted, aclk, aresetn, valid_reg && next_data.valid,
                       key_reg < next_data.key, "cell chain is not in ascending key order")
    `MCMQ_ASSERT_IMPLY(a_packed, aclk, aresetn, !valid_reg, !next_data.valid,
                       "valid entry found behind an empty cell")

endmodule

FILE: hw/rtl/multi_class_min_extract_queue.sv
`timescale 1ns / 1ps
// ============================================================================
// Multi-class min-extract queue
// Sequence: each transaction takes a compare pass (ST_CMP), then a shift
// pass of the cell chain (ST_UPD) that registers its result. The next one
// can be taken in that shift pass, which waits until the result is drained.
// Reset: aresetn empties the store and clears the result channel at once.
// ============================================================================
`include "multi_class_min_extract_queue_defines.svh"

module multi_class_min_extract_queue
    import mcmq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // key_value[29:0], first_class[31:30], second_class[33:32],
    // wanted_class[35:34], zero fill [39:36]
    input  logic [S_TDATA_W-1:0] s_tdata,
    // func[0]
    input  logic [0:0]           s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // key_out[29:0], zero fill [31:30]
    output logic [M_TDATA_W-1:0] m_tdata,
    // status[1:0]
    output logic [STATUS_W-1:0]  m_tuser
);

    seq_state_t state_reg, state_next;

    logic              func_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] want_reg;

    logic [ENTRIES-1:0] match_vec, gt_vec, eq_vec;
    logic [ENTRIES-1:0] prefix_reg, first_reg;
    cell_data_t         cell_data [ENTRIES];
    cell_ctrl_t         ctrl;

    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [KEY_W-1:0]    m_key_reg;

    logic              out_free, accept, commit, cmp_en;
    logic              hit, full, found;
    logic [KEY_W-1:0]  sel_key;

    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Sequencer: next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_CMP;
            ST_CMP:  state_next = ST_UPD;
            ST_UPD: begin
                if (out_free) begin
                    state_next = accept ? ST_CMP : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer: outputs
    always_comb begin
        s_tready = 1'b0;
        cmp_en   = 1'b0;
        commit   = 1'b0;
        unique case (state_reg)
            ST_IDLE: s_tready = 1'b1;
            ST_CMP:  cmp_en = 1'b1;
            ST_UPD: begin
                s_tready = out_free;
                commit   = out_free;
            end
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg <= s_tuser[0];
            key_reg  <= s_tdata[KEY_W-1:0];
            mask_reg <= class_bit(s_tdata[31:30]) | class_bit(s_tdata[33:32]);
            want_reg <= class_bit(s_tdata[35:34]);
        end
    end

    // The first matching cell and every cell behind it move one place toward
    // the head; the carry chain of the two's complement marks them.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prefix_reg <= '0;
            first_reg  <= '0;
        end else if (cmp_en) begin
            prefix_reg <= match_vec | (~match_vec + ENTRIES'(1));
            first_reg  <= match_vec & (~match_vec + ENTRIES'(1));
        end
    end

    assign hit   = |eq_vec;
    assign full  = cell_data[ENTRIES-1].valid;
    assign found = |first_reg;

    always_comb begin
        ctrl.cmp_en = cmp_en;
        ctrl.commit = commit;
        ctrl.func   = func_reg;
        ctrl.key    = key_reg;
        ctrl.mask   = mask_reg;
        ctrl.want   = want_reg;
        ctrl.hit    = hit;
        ctrl.full   = full;
        ctrl.found  = found;
    end

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
            cell_data_t prev_d, next_d;
            logic       prev_g;
            if (gi == 0) begin : g_head
                assign prev_d = EMPTY_CELL;
                assign prev_g = 1'b0;
            end else begin : g_body
                assign prev_d = cell_data[gi-1];
                assign prev_g = gt_vec[gi-1];
            end
            if (gi == ENTRIES - 1) begin : g_tail
                assign next_d = EMPTY_CELL;
            end else begin : g_link
                assign next_d = cell_data[gi+1];
            end
            mcmq_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .prev_data  (prev_d),
                .prev_gt    (prev_g),
                .next_data  (next_d),
                .shift_down (prefix_reg[gi]),
                .data       (cell_data[gi]),
                .gt         (gt_vec[gi]),
                .eq         (eq_vec[gi]),
                .match      (match_vec[gi])
            );
        end
    endgenerate

    always_comb begin
        sel_key = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            sel_key = sel_key | (first_reg[i] ? cell_data[i].key : '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            if (func_reg == FUNC_INSERT) begin
                m_status_reg <= (!hit && full) ? STAT_FULL : STAT_STORED;
                m_key_reg    <= '0;
            end else begin
                m_status_reg <= found ? STAT_FOUND : STAT_NONE;
                m_key_reg    <= sel_key;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {{(M_TDATA_W-KEY_W){1'b0}}, m_key_reg};

    `MCMQ_ASSERT_IMPLY(a_key_zero, aclk, aresetn, m_tvalid_reg && (m_status_reg != STAT_FOUND),
                       m_key_reg == '0, "key_out is not zero without a returned key")
    `MCMQ_ASSERT_NEVER(a_first_onehot, aclk, aresetn, !$onehot0(first_reg),
                       "more than one cell selected for extraction")
    `MCMQ_ASSERT_IMPLY(a_result_src, aclk, aresetn, $rose(m_tvalid_reg),
                       $past(state_reg) == ST_UPD, "result raised outside the update pass")

endmodule

FILE: dv/mcmq_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// Multi-class min-extract queue checker
// Follows every accepted request with its own copy of the store, predicts
// the reply and compares each accepted reply with the oldest one predicted.
// ============================================================================
module mcmq_checker
    import mcmq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic [STATUS_W-1:0]  m_tuser,
    output int                   fail_count,
    output int                   outstanding
);

    localparam int FIRST_LSB  = KEY_W;
    localparam int SECOND_LSB = KEY_W + TAG_W;
    localparam int WANTED_LSB = KEY_W + 2 * TAG_W;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key_out;
    } queue_reply_t;

    logic              shadow_valid [ENTRIES];
    logic [KEY_W-1:0]  shadow_key   [ENTRIES];
    logic [MASK_W-1:0] shadow_mask  [ENTRIES];
    queue_reply_t      pending_replies [$];
    int                reply_index;

    // Tag zero stands for no class at all.
    function automatic logic [MASK_W-1:0] tag_to_mask(input logic [TAG_W-1:0] tag);
        return (tag == '0) ? '0 : (MASK_W'(1) << (tag - 1'b1));
    endfunction

    function automatic queue_reply_t predict_reply(input logic func,
                                                   input logic [S_TDATA_W-1:0] data);
        logic [KEY_W-1:0]  key;
        logic [MASK_W-1:0] mask;
        logic [MASK_W-1:0] wanted;
        int                hit;
        int                free_idx;
        int                best;
        queue_reply_t      r;
        key      = data[KEY_W-1:0];
        mask     = tag_to_mask(data[FIRST_LSB +: TAG_W]) |
                   tag_to_mask(data[SECOND_LSB +: TAG_W]);
        wanted   = tag_to_mask(data[WANTED_LSB +: TAG_W]);
        hit      = -1;
        free_idx = -1;
        best     = -1;
        r        = '0;
        if (func == FUNC_INSERT) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (shadow_valid[i]) begin
                    if (hit < 0 && shadow_key[i] == key)
                        hit = i;
                end else if (free_idx < 0) begin
                    free_idx = i;
                end
            end
            if (hit >= 0) begin
                shadow_mask[hit] = mask;
                r.status = STAT_STORED;
            end else if (free_idx >= 0) begin
                shadow_valid[free_idx] = 1'b1;
                shadow_key[free_idx]   = key;
                shadow_mask[free_idx]  = mask;
                r.status = STAT_STORED;
            end else begin
                r.status = STAT_FULL;
            end
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (shadow_valid[i] && (shadow_mask[i] & wanted) != '0 &&
                    (best < 0 || shadow_key[i] < shadow_key[best]))
                    best = i;
            end
            if (best >= 0) begin
                r.status  = STAT_FOUND;
                r.key_out = shadow_key[best];
                shadow_valid[best] = 1'b0;
            end else begin
                r.status = STAT_NONE;
            end
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        queue_reply_t expected_reply;
        queue_reply_t seen_reply;
        if (!aresetn) begin
            pending_replies.delete();
            foreach (shadow_valid[i])
                shadow_valid[i] = 1'b0;
            fail_count  = 0;
            reply_index = 0;
        end else begin
            if (s_tvalid && s_tready)
                pending_replies.push_back(predict_reply(s_tuser[0], s_tdata));
            if (m_tvalid && m_tready) begin
                seen_reply.status  = m_tuser;
                seen_reply.key_out = m_tdata[KEY_W-1:0];
                if (pending_replies.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("reply %0d: unexpected, status %0d key %h",
                                 reply_index, seen_reply.status, seen_reply.key_out);
                    fail_count++;
                end else begin
                    expected_reply = pending_replies.pop_front();
                    if (seen_reply.status !== expected_reply.status ||
                        seen_reply.key_out !== expected_reply.key_out) begin
                        if (fail_count < MAX_REPORTS)
                            $display("reply %0d: expected status %0d key %h, got status %0d key %h",
                                     reply_index, expected_reply.status,
                                     expected_reply.key_out, seen_reply.status,
                                     seen_reply.key_out);
                        fail_count++;
                    end
                end
                reply_index++;
            end
        end
        outstanding = pending_replies.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// Multi-class min-extract queue testbench
// Drives directed and random insert and query transactions under several
// idling patterns, fills the store past its size, and takes the verdict
// from the checker that runs beside the block.
// ============================================================================
module tb_top;
    import mcmq_pkg::*;

    localparam int RANDOM_ITEMS  = 1330;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int FILL_INSERTS  = 264;
    localparam int FILL_QUERIES  = 280;
    localparam int DRAIN_CYCLES  = 10;
    localparam int FILL_BITS     = S_TDATA_W - KEY_W - 3 * TAG_W;
    localparam logic [KEY_W-1:0] KEY_MAX = '1;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [0:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    int   fail_count;
    int   outstanding;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   items_sent     = 0;
    int   cycle_count    = 0;
    logic hold_off_req   = 1'b0;
    logic hold_off_done  = 1'b0;

    multi_class_min_extract_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    mcmq_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off when it is requested.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_done = 1'b1;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Class tags are mostly valid, with an occasional zero tag.
    function automatic logic [TAG_W-1:0] random_tag();
        return ($urandom_range(9) == 0) ? '0 : TAG_W'($urandom_range(3, 1));
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic func, input logic [KEY_W-1:0] key,
                             input logic [TAG_W-1:0] first_tag,
                             input logic [TAG_W-1:0] second_tag,
                             input logic [TAG_W-1:0] wanted_tag);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{FILL_BITS{1'b0}}, wanted_tag, second_tag, first_tag, key};
        s_tuser  <= func;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
    endtask

    // Inserts more fresh keys than the store holds, then queries most of them back.
    task automatic fill_and_drain();
        logic [KEY_W-1:0] first_key;
        logic [KEY_W-1:0] key;
        first_key = KEY_W'($urandom);
        for (int n = 0; n < FILL_INSERTS; n++) begin
            key = (n == 0) ? first_key : KEY_W'($urandom);
            send_item(FUNC_INSERT, key, random_tag(), random_tag(), TAG_W'($urandom));
        end
        // With the store full, a key that is already stored only has its tags replaced.
        send_item(FUNC_INSERT, first_key, 2'd1, 2'd3, TAG_W'($urandom));
        for (int n = 0; n < FILL_QUERIES; n++)
            send_item(FUNC_QUERY, KEY_W'($urandom), TAG_W'($urandom), TAG_W'($urandom),
                      TAG_W'($urandom_range(3, 1)));
    endtask

    // A small key pool makes repeated keys common.
    task automatic mixed_item();
        logic [KEY_W-1:0] key;
        key = ($urandom_range(1) == 0) ? KEY_W'($urandom_range(63)) : KEY_W'($urandom);
        send_item(($urandom_range(99) < 55) ? FUNC_INSERT : FUNC_QUERY, key,
                  random_tag(), random_tag(), random_tag());
    endtask

    initial begin
        int random_base;
        int phase_end;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_INSERT;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: empty store, key extremes, zero tags, tag replacement.
        send_item(FUNC_QUERY,  '0,      2'd0, 2'd0, 2'd1);
        send_item(FUNC_QUERY,  KEY_MAX, 2'd3, 2'd3, 2'd0);
        send_item(FUNC_INSERT, '0,      2'd1, 2'd1, 2'd0);
        send_item(FUNC_INSERT, KEY_MAX, 2'd3, 2'd2, 2'd3);
        send_item(FUNC_INSERT, 30'd5,   2'd2, 2'd2, 2'd0);
        send_item(FUNC_INSERT, 30'd5,   2'd0, 2'd0, 2'd0);
        send_item(FUNC_INSERT, 30'd7,   2'd0, 2'd0, 2'd0);
        send_item(FUNC_QUERY,  '0,      2'd0, 2'd0, 2'd2);
        send_item(FUNC_QUERY,  '0,      2'd0, 2'd0, 2'd3);
        send_item(FUNC_INSERT, 30'd5,   2'd3, 2'd1, 2'd0);
        send_item(FUNC_QUERY,  KEY_MAX, 2'd3, 2'd3, 2'd3);
        send_item(FUNC_QUERY,  '0,      2'd0, 2'd0, 2'd1);
        send_item(FUNC_QUERY,  '0,      2'd0, 2'd0, 2'd1);
        send_item(FUNC_INSERT, 30'd7,   2'd2, 2'd3, 2'd0);
        send_item(FUNC_QUERY,  KEY_MAX, 2'd3, 2'd3, 2'd0);
        send_item(FUNC_QUERY,  '0,      2'd0, 2'd0, 2'd2);
        send_item(FUNC_INSERT, 30'h2AAAAAAA, 2'd1, 2'd3, 2'd0);
        send_item(FUNC_INSERT, 30'h15555555, 2'd3, 2'd1, 2'd0);
        send_item(FUNC_QUERY,  '0,      2'd0, 2'd0, 2'd1);
        send_item(FUNC_QUERY,  '0,      2'd0, 2'd0, 2'd3);
        send_item(FUNC_QUERY,  '0,      2'd0, 2'd0, 2'd3);
        wait_drained();

        random_base = items_sent;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 9;
                    recv_stall_pct = 9;
                end
            endcase
            phase_end = random_base + (ph + 1) * RANDOM_ITEMS / 4;
            // The first fill runs against a long hold-off so the block backs up.
            if (ph == 0)
                hold_off_req = 1'b1;
            if (ph == 0 || ph == 2)
                fill_and_drain();
            while (items_sent < phase_end)
                mixed_item();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
